@@ design/tidt_pkg.sv @@
// shared types and constants for the tiled intensity texture detiler
// no dependencies; imported by the front, queue, back and top level
package tidt_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int INDEX_W     = 20;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    localparam logic [CFG_INDEX_W-1:0] REG_FORMAT_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TILES_ACROSS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TILES_DOWN   = 2'd2;

    localparam logic MODE_I4 = 1'b0;
    localparam logic MODE_I8 = 1'b1;

    // one classified source byte, handed from front to back
    typedef struct packed {
        logic [7:0]         src_byte;
        logic [INDEX_W-1:0] pixel_index;
        logic               image_done;
        logic               wide;
    } tidt_entry_t;

endpackage

@@ design/tidt_if.sv @@
// valid/ready channel interfaces for source bytes and pixel writes
// depends on nothing
interface tidt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;

    modport source (output valid, output src_byte, input ready);
    modport sink (input valid, input src_byte, output ready);
endinterface

interface tidt_pixel_if;
    logic        valid;
    logic        ready;
    logic [19:0] pixel_index;
    logic [31:0] pixel_value;
    logic        last_of_item;
    logic        image_done;

    modport source (output valid, output pixel_index, output pixel_value,
                    output last_of_item, output image_done, input ready);
    modport sink (input valid, input pixel_index, input pixel_value,
                  input last_of_item, input image_done, output ready);
endinterface

@@ design/tidt_front.sv @@
// front end: configuration registers, tile walk counters and index generation
// depends on tidt_pkg and tidt_byte_if
module tidt_front #(
    parameter int MAX_WIDTH_PIXELS  = 1024,
    parameter int MAX_HEIGHT_PIXELS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             write_en,
    input  logic [tidt_pkg::CFG_INDEX_W-1:0] write_index,
    input  logic [tidt_pkg::CFG_DATA_W-1:0]  write_data,
    tidt_byte_if.sink                        texels,
    input  logic                             q_full,
    output logic                             q_push,
    output tidt_pkg::tidt_entry_t            q_entry
);
    import tidt_pkg::*;

    localparam int unsigned ACROSS_MAX  = MAX_WIDTH_PIXELS / 8;
    localparam int unsigned DOWN_MAX_I4 = (MAX_HEIGHT_PIXELS / 8 < 1) ? 1
                                                                     : MAX_HEIGHT_PIXELS / 8;
    localparam int unsigned DOWN_MAX_I8 = MAX_HEIGHT_PIXELS / 4;

    logic                format_mode_reg;
    logic [7:0]          tiles_across_reg;
    logic [8:0]          tiles_down_reg;

    logic [7:0]          tile_col_reg;
    logic [8:0]          tile_row_reg;
    logic [2:0]          row_in_tile_reg;
    logic [2:0]          byte_in_row_reg;
    logic [INDEX_W-1:0]  tile_row_base_reg;
    logic [INDEX_W-1:0]  row_off_reg;
    logic [INDEX_W-1:0]  col_off_reg;

    logic [7:0]          ta;
    logic [8:0]          td;
    int unsigned         down_max;
    logic [2:0]          th_m1;
    logic [2:0]          bpr_m1;
    logic [10:0]         width;
    logic [INDEX_W-1:0]  tile_step;
    logic [3:0]          byte_off;
    logic                last_byte;
    logic                last_row;
    logic                last_col;
    logic                last_trow;
    logic                done;

    always_comb
    begin
        if (tiles_across_reg == 8'd0)
            ta = 8'd1;
        else if (32'(tiles_across_reg) > ACROSS_MAX)
            ta = ACROSS_MAX[7:0];
        else
            ta = tiles_across_reg;

        down_max = (format_mode_reg == MODE_I8) ? DOWN_MAX_I8 : DOWN_MAX_I4;
        if (tiles_down_reg == 9'd0)
            td = 9'd1;
        else if (32'(tiles_down_reg) > down_max)
            td = down_max[8:0];
        else
            td = tiles_down_reg;
    end

    assign th_m1     = (format_mode_reg == MODE_I8) ? 3'd3 : 3'd7;
    assign bpr_m1    = (format_mode_reg == MODE_I8) ? 3'd7 : 3'd3;
    assign width     = {ta, 3'b000};
    // one tile row of pixels: width times tile height
    assign tile_step = (format_mode_reg == MODE_I8) ? {7'd0, width, 2'b00}
                                                    : {6'd0, width, 3'b000};
    assign byte_off  = (format_mode_reg == MODE_I8) ? {1'b0, byte_in_row_reg}
                                                    : {byte_in_row_reg, 1'b0};

    assign last_byte = (byte_in_row_reg == bpr_m1);
    assign last_row  = (row_in_tile_reg == th_m1);
    assign last_col  = (tile_col_reg == ta - 8'd1);
    assign last_trow = (tile_row_reg == td - 9'd1);
    assign done      = last_byte && last_row && last_col && last_trow;

    assign texels.ready = !q_full;
    assign q_push       = texels.valid && !q_full;

    always_comb
    begin
        q_entry.src_byte    = texels.src_byte;
        q_entry.pixel_index = tile_row_base_reg + row_off_reg + col_off_reg
                              + {16'd0, byte_off};
        q_entry.image_done  = done;
        q_entry.wide        = (format_mode_reg == MODE_I8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_mode_reg   <= MODE_I4;
            tiles_across_reg  <= 8'd1;
            tiles_down_reg    <= 9'd1;
            tile_col_reg      <= '0;
            tile_row_reg      <= '0;
            row_in_tile_reg   <= '0;
            byte_in_row_reg   <= '0;
            tile_row_base_reg <= '0;
            row_off_reg       <= '0;
            col_off_reg       <= '0;
        end
        else if (write_en)
        begin
            // any known register restarts the image
            if (write_index == REG_FORMAT_MODE || write_index == REG_TILES_ACROSS ||
                write_index == REG_TILES_DOWN)
            begin
                tile_col_reg      <= '0;
                tile_row_reg      <= '0;
                row_in_tile_reg   <= '0;
                byte_in_row_reg   <= '0;
                tile_row_base_reg <= '0;
                row_off_reg       <= '0;
                col_off_reg       <= '0;
            end
            case (write_index)
                REG_FORMAT_MODE:  format_mode_reg  <= write_data[0];
                REG_TILES_ACROSS: tiles_across_reg <= write_data[7:0];
                REG_TILES_DOWN:   tiles_down_reg   <= write_data[8:0];
                default:          ;
            endcase
        end
        else if (q_push)
        begin
            if (done)
            begin
                tile_col_reg      <= '0;
                tile_row_reg      <= '0;
                row_in_tile_reg   <= '0;
                byte_in_row_reg   <= '0;
                tile_row_base_reg <= '0;
                row_off_reg       <= '0;
                col_off_reg       <= '0;
            end
            else if (last_byte)
            begin
                byte_in_row_reg <= '0;
                if (last_row)
                begin
                    row_in_tile_reg <= '0;
                    row_off_reg     <= '0;
                    if (last_col)
                    begin
                        tile_col_reg      <= '0;
                        col_off_reg       <= '0;
                        tile_row_reg      <= tile_row_reg + 9'd1;
                        tile_row_base_reg <= tile_row_base_reg + tile_step;
                    end
                    else
                    begin
                        tile_col_reg <= tile_col_reg + 8'd1;
                        col_off_reg  <= col_off_reg + INDEX_W'(8);
                    end
                end
                else
                begin
                    row_in_tile_reg <= row_in_tile_reg + 3'd1;
                    row_off_reg     <= row_off_reg + {9'd0, width};
                end
            end
            else
            begin
                byte_in_row_reg <= byte_in_row_reg + 3'd1;
            end
        end
    end

endmodule

@@ design/tidt_queue.sv @@
// short fifo of classified bytes between front and back
// depends on tidt_pkg
module tidt_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tidt_pkg::tidt_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  nonempty,
    output tidt_pkg::tidt_entry_t head
);
    import tidt_pkg::*;

    tidt_entry_t         slots_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;

    assign full     = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

@@ design/tidt_back.sv @@
// back end: expands each byte into one or two rgba32 pixel writes
// depends on tidt_pkg and tidt_pixel_if
module tidt_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_nonempty,
    input  tidt_pkg::tidt_entry_t q_head,
    output logic                  q_pop,
    tidt_pixel_if.source          pixels
);
    import tidt_pkg::*;

    logic                valid_reg;
    logic                phase_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [31:0]         value_reg;
    logic                last_reg;
    logic                done_reg;

    logic                load;
    logic                last_pix;
    logic [3:0]          nibble;
    logic [7:0]          intensity;

    assign load     = q_nonempty && (!valid_reg || pixels.ready);
    // i8 bytes and the low nibble of an i4 byte finish the item
    assign last_pix = q_head.wide || phase_reg;
    assign q_pop    = load && last_pix;
    assign nibble   = phase_reg ? q_head.src_byte[3:0] : q_head.src_byte[7:4];
    assign intensity = q_head.wide ? q_head.src_byte : {nibble, nibble};

    assign pixels.valid        = valid_reg;
    assign pixels.pixel_index  = index_reg;
    assign pixels.pixel_value  = value_reg;
    assign pixels.last_of_item = last_reg;
    assign pixels.image_done   = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                phase_reg <= !last_pix;
            end
            else if (pixels.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index_reg <= q_head.pixel_index + {{(INDEX_W-1){1'b0}}, phase_reg};
            value_reg <= {4{intensity}};
            last_reg  <= last_pix;
            done_reg  <= last_pix && q_head.image_done;
        end
    end

endmodule

@@ design/tiled_intensity_texture_detiler.sv @@
// top level of the tiled intensity texture detiler
// depends on tidt_pkg, tidt_if, tidt_front, tidt_queue and tidt_back
//
// Takes source bytes of an I4 or I8 tiled texture in storage order and emits
// linear RGBA32 pixel writes, one per cycle while the pixel port is ready. An
// I8 byte gives one pixel, an I4 byte two, via the single pixel output register
// in the back end; a two-entry queue lets bytes keep arriving while a pixel
// waits for its transfer. Any write to a known register restarts the image.
module tiled_intensity_texture_detiler #(
    parameter int MAX_WIDTH_PIXELS  = 1024,
    parameter int MAX_HEIGHT_PIXELS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             write_en,
    input  logic [tidt_pkg::CFG_INDEX_W-1:0] write_index,
    input  logic [tidt_pkg::CFG_DATA_W-1:0]  write_data,
    tidt_byte_if.sink                        texels,
    tidt_pixel_if.source                     pixels
);
    import tidt_pkg::*;

    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_nonempty;
    tidt_entry_t q_entry;
    tidt_entry_t q_head;

    tidt_front #(
        .MAX_WIDTH_PIXELS  (MAX_WIDTH_PIXELS),
        .MAX_HEIGHT_PIXELS (MAX_HEIGHT_PIXELS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data),
        .texels      (texels),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    tidt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .nonempty   (q_nonempty),
        .head       (q_head)
    );

    tidt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .pixels     (pixels)
    );

endmodule
